>>> hw/rtl/tdl_pkg.sv
// Package for the thermocouple dead-band logger.
// Field widths, register indexes, result type and magnitude helper.
// No dependencies.
`timescale 1ns / 1ps

package tdl_pkg;

	localparam int unsigned ValueW  = 14;
	localparam int unsigned WholeW  = 11;
	localparam int unsigned TenthsW = 4;
	localparam int unsigned ThreshW = 13;
	localparam int unsigned ByteW   = 8;
	localparam int unsigned CfgIdxW = 1;
	localparam int unsigned CfgW    = ThreshW;
	localparam int unsigned NumCh   = 2;

	localparam logic [ValueW-1:0]  SignBit   = 14'h2000;
	localparam logic [ValueW-1:0]  TagCh1    = 14'h0100;
	localparam logic [ValueW-1:0]  TagCh2    = 14'h0200;
	localparam logic [ValueW-1:0]  FltCh1    = 14'h0400;
	localparam logic [ValueW-1:0]  FltCh2    = 14'h0800;
	localparam logic [ThreshW-1:0] ThreshRst = 13'd3;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_RECORD_ENABLE    = 1'b0,
		CFG_CHANGE_THRESHOLD = 1'b1
	} tdl_cfg_idx_t;

	typedef struct packed {
		logic               fault_seen;
		logic               log_valid;
		logic [ValueW-1:0]  log_word;
		logic               negative;
		logic [WholeW-1:0]  whole_degrees;
		logic [TenthsW-1:0] tenths_digit;
		logic               last;
	} tdl_result_t;

	function automatic logic [ValueW-1:0] mag_of(input logic [ValueW-1:0] v);
		logic [ValueW-1:0] m;
		if (v[ValueW-1]) begin
			m = ~v + 14'd1;
		end else begin
			m = v;
		end
		return m;
	endfunction

endpackage

>>> hw/rtl/tdl_if.sv
// Valid/ready channel interfaces for the dead-band logger.
// Reading channel and result channel; uses tdl_pkg widths.
`timescale 1ns / 1ps

interface tdl_in_if import tdl_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             channel_select;
	logic [ByteW-1:0] raw_high;
	logic [ByteW-1:0] raw_mid;
	logic             fault_flag;
	logic [ByteW-1:0] time_stamp;

	modport source (output valid, channel_select, raw_high, raw_mid, fault_flag, time_stamp,
		input ready);
	modport sink (input valid, channel_select, raw_high, raw_mid, fault_flag, time_stamp,
		output ready);
endinterface

interface tdl_out_if import tdl_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               fault_seen;
	logic               log_valid;
	logic [ValueW-1:0]  log_word;
	logic               negative;
	logic [WholeW-1:0]  whole_degrees;
	logic [TenthsW-1:0] tenths_digit;
	logic               last;

	modport source (output valid, fault_seen, log_valid, log_word, negative, whole_degrees,
		tenths_digit, last, input ready);
	modport sink (input valid, fault_seen, log_valid, log_word, negative, whole_degrees,
		tenths_digit, last, output ready);
endinterface

>>> hw/rtl/thermocouple_deadband_logger_unit.sv
// Top level of the thermocouple dead-band logger.
// Uses tdl_pkg and the channel interfaces in tdl_if.sv.
`timescale 1ns / 1ps

// Takes one reading per word on in_ch and returns one result word, or two when
// the reading is logged (time word, then raw value). A reading is accepted every
// cycle unless the s1 stage is stalled by out_ch back-pressure or by a logged
// reading, whose time word in a_q and raw value in b_q must both be taken before
// the next result loads. A reading is registered in the s1 stage, then its result
// in a_q, which drives out_ch. Write record_enable and change_threshold through
// cfg_we/cfg_index/cfg_data only while no reading is in flight.
module thermocouple_deadband_logger_unit
	import tdl_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	tdl_in_if.sink             in_ch,
	tdl_out_if.source          out_ch,
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [CfgW-1:0]    cfg_data
);

	logic               record_enable_q;
	logic [ThreshW-1:0] change_threshold_q;
	logic [ValueW-1:0]  logged_value_q [NumCh];
	logic [NumCh-1:0]   channel_faulted_q;

	logic             valid_s1;
	logic             channel_select_s1;
	logic [ByteW-1:0] raw_high_s1;
	logic [ByteW-1:0] raw_mid_s1;
	logic             fault_flag_s1;
	logic [ByteW-1:0] time_stamp_s1;

	tdl_result_t a_q;
	tdl_result_t b_q;
	logic        a_valid_q;
	logic        b_pend_q;

	logic              in_acc;
	logic              out_take;
	logic              load;
	logic [ValueW-1:0] value;
	logic [ValueW-1:0] mag;
	logic [ValueW-1:0] prev;
	logic [ValueW-1:0] prev_mag;
	logic [ValueW-1:0] diff;
	logic [ValueW-1:0] time_word;
	logic [TenthsW-1:0] frac;
	logic              do_log;
	tdl_result_t       first;
	tdl_result_t       second;

	assign in_acc   = in_ch.valid && in_ch.ready;
	assign out_take = a_valid_q && out_ch.ready;
	assign load     = valid_s1 && (!a_valid_q || (out_take && !b_pend_q));
	assign in_ch.ready = !valid_s1 || load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			record_enable_q    <= 1'b0;
			change_threshold_q <= ThreshRst;
		end else if (cfg_we) begin
			unique case (tdl_cfg_idx_t'(cfg_index))
				CFG_RECORD_ENABLE:    record_enable_q    <= cfg_data[0];
				CFG_CHANGE_THRESHOLD: change_threshold_q <= cfg_data[ThreshW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			channel_select_s1 <= in_ch.channel_select;
			raw_high_s1       <= in_ch.raw_high;
			raw_mid_s1        <= in_ch.raw_mid;
			fault_flag_s1     <= in_ch.fault_flag;
			time_stamp_s1     <= in_ch.time_stamp;
		end
	end

	always_comb begin
		value    = {raw_high_s1[7], raw_high_s1[5:0], raw_mid_s1[7:1]};
		mag      = mag_of(value);
		frac     = {1'b0, mag[2:0]};
		if (frac > 4'd3) begin
			frac = frac + 4'd1;
		end
		if (mag[3] && ((frac == 4'd8) || (value[ValueW-1] && (frac == 4'd3)))) begin
			frac = frac + 4'd1;
		end
		prev     = logged_value_q[channel_select_s1];
		prev_mag = mag_of(prev);
		diff     = (mag > prev_mag) ? (mag - prev_mag) : (prev_mag - mag);
		do_log   = !fault_flag_s1 && record_enable_q &&
			((prev[ValueW-1] != value[ValueW-1]) || (diff > {1'b0, change_threshold_q}));
		time_word = SignBit | {{(ValueW-ByteW){1'b0}}, time_stamp_s1} |
			(channel_select_s1 ? TagCh2 : TagCh1);
		if (channel_faulted_q[channel_select_s1]) begin
			time_word = time_word | (channel_select_s1 ? FltCh2 : FltCh1);
		end

		first               = '0;
		first.negative      = value[ValueW-1];
		first.whole_degrees = mag[ValueW-1:3];
		first.tenths_digit  = frac;
		first.log_valid     = do_log;
		first.log_word      = do_log ? time_word : '0;
		first.last          = !do_log;
		if (fault_flag_s1) begin
			first            = '0;
			first.fault_seen = 1'b1;
			first.last       = 1'b1;
		end
		second          = first;
		second.log_word = value;
		second.last     = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			logged_value_q[0] <= '0;
			logged_value_q[1] <= '0;
			channel_faulted_q <= '0;
		end else if (load) begin
			channel_faulted_q[channel_select_s1] <= fault_flag_s1;
			if (do_log) begin
				logged_value_q[channel_select_s1] <= value;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_valid_q <= 1'b0;
			b_pend_q  <= 1'b0;
		end else if (load) begin
			a_valid_q <= 1'b1;
			b_pend_q  <= do_log;
		end else if (out_take) begin
			a_valid_q <= b_pend_q;
			b_pend_q  <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			a_q <= first;
			b_q <= second;
		end else if (out_take && b_pend_q) begin
			a_q <= b_q;
		end
	end

	assign out_ch.valid         = a_valid_q;
	assign out_ch.fault_seen    = a_q.fault_seen;
	assign out_ch.log_valid     = a_q.log_valid;
	assign out_ch.log_word      = a_q.log_word;
	assign out_ch.negative      = a_q.negative;
	assign out_ch.whole_degrees = a_q.whole_degrees;
	assign out_ch.tenths_digit  = a_q.tenths_digit;
	assign out_ch.last          = a_q.last;

	a_pend_needs_valid: assert property (@(posedge clk) disable iff (!arst_n)
		b_pend_q |-> a_valid_q)
		else $error("second log word pending without a word on the output");

	a_pend_first_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		b_pend_q |-> (!a_q.last && a_q.log_valid))
		else $error("time word marked last while raw word pending");

	a_second_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(out_take && b_pend_q) |=> (a_valid_q && a_q.last && a_q.log_valid))
		else $error("raw log word did not follow the time word");

	a_fault_no_log: assert property (@(posedge clk) disable iff (!arst_n)
		(a_valid_q && a_q.fault_seen) |-> (!a_q.log_valid && a_q.last))
		else $error("faulted reading produced a log word");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Testbench for thermocouple_deadband_logger_unit: a directed table, then random readings
// under changing dead-band settings, each result word checked against the table
// or a local model. Depends on tdl_pkg and the channel interfaces in tdl_if.sv.

module testbench;
	import tdl_pkg::*;

	localparam int unsigned RandomReadings = 1250;
	localparam int unsigned PhaseLen       = 125;
	localparam int unsigned CycleLimit     = 400000;

	typedef struct {
		bit             ch;
		bit [ByteW-1:0] hi;
		bit [ByteW-1:0] mid;
		bit             flt;
		bit [ByteW-1:0] ts;
	} reading_t;

	typedef enum {STEP_READ, STEP_CONFIG} step_kind_t;

	typedef struct {
		step_kind_t       kind;
		reading_t         rd;
		bit               rec;
		bit [ThreshW-1:0] thr;
		bit               known;
		tdl_result_t      want;
	} step_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [CfgIdxW-1:0] cfg_index;
	logic [CfgW-1:0]    cfg_data;

	tdl_in_if  in_ch();
	tdl_out_if out_ch();

	thermocouple_deadband_logger_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	bit [ValueW-1:0]  logged_val [NumCh];
	bit               ch_faulted [NumCh];
	bit               rec_on;
	bit [ThreshW-1:0] thresh;
	tdl_result_t      pending_results [$];
	step_t            plan [$];
	int               errors;
	int               burst_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int convert_reading(input reading_t r, output tdl_result_t res [2]);
		bit [ValueW-1:0]  value;
		bit [ValueW-1:0]  mag;
		bit [ValueW-1:0]  prev_mag;
		bit [ValueW-1:0]  diff;
		bit [ValueW-1:0]  tw;
		bit [TenthsW-1:0] tenths;
		bit               neg;
		bit               logged;
		tdl_result_t      shown;
		res[0] = '0;
		res[1] = '0;
		if (r.flt) begin
			ch_faulted[r.ch] = 1'b1;
			res[0].fault_seen = 1'b1;
			res[0].last = 1'b1;
			return 1;
		end
		value = {r.hi[7], r.hi[5:0], r.mid[7:1]};
		neg = value[ValueW-1];
		mag = neg ? 14'h0 - value : value;
		tenths = {1'b0, mag[2:0]};
		if (tenths > 4'd3)
			tenths = tenths + 4'd1;
		if (mag[3] && ((neg && tenths == 4'd3) || tenths == 4'd8))
			tenths = tenths + 4'd1;
		logged = 1'b0;
		if (rec_on) begin
			prev_mag = logged_val[r.ch][ValueW-1] ? 14'h0 - logged_val[r.ch] : logged_val[r.ch];
			diff = (mag > prev_mag) ? mag - prev_mag : prev_mag - mag;
			logged = (logged_val[r.ch][ValueW-1] != neg) || (diff > thresh);
		end
		shown = '0;
		shown.negative = neg;
		shown.whole_degrees = mag[ValueW-1:3];
		shown.tenths_digit = tenths;
		if (!logged) begin
			ch_faulted[r.ch] = 1'b0;
			res[0] = shown;
			res[0].last = 1'b1;
			return 1;
		end
		tw = SignBit | {6'd0, r.ts} | (r.ch ? TagCh2 : TagCh1);
		if (ch_faulted[r.ch])
			tw = tw | (r.ch ? FltCh2 : FltCh1);
		logged_val[r.ch] = value;
		ch_faulted[r.ch] = 1'b0;
		res[0] = shown;
		res[0].log_valid = 1'b1;
		res[0].log_word = tw;
		res[1] = shown;
		res[1].log_valid = 1'b1;
		res[1].log_word = value;
		res[1].last = 1'b1;
		return 2;
	endfunction

	function automatic int next_gap();
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		burst_left = $urandom_range(0, 24);
		return ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 8));
	endfunction

	function automatic void add_read(input bit ch, input bit [7:0] hi, input bit [7:0] mid,
			input bit flt, input bit [7:0] ts);
		step_t s;
		s = '{kind: STEP_READ, default: '0};
		s.rd = '{ch: ch, hi: hi, mid: mid, flt: flt, ts: ts};
		plan.push_back(s);
	endfunction

	function automatic void add_known(input bit ch, input bit [7:0] hi, input bit [7:0] mid,
			input bit flt, input bit neg, input bit [WholeW-1:0] whole,
			input bit [TenthsW-1:0] tenths);
		tdl_result_t w;
		add_read(ch, hi, mid, flt, flt ? 8'hFF : 8'h00);
		w = '0;
		w.fault_seen = flt;
		w.negative = neg;
		w.whole_degrees = whole;
		w.tenths_digit = tenths;
		w.last = 1'b1;
		plan[$].known = 1'b1;
		plan[$].want = w;
	endfunction

	function automatic void add_config(input bit rec, input bit [ThreshW-1:0] thr);
		step_t s;
		s = '{kind: STEP_CONFIG, default: '0};
		s.rec = rec;
		s.thr = thr;
		plan.push_back(s);
	endfunction

	// hold valid low and wait until every expected word is back
	task automatic drain_results();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic write_config(input bit rec, input bit [ThreshW-1:0] thr);
		drain_results();
		cfg_we <= 1'b1;
		cfg_index <= CFG_RECORD_ENABLE;
		cfg_data <= CfgW'(rec);
		@(posedge clk);
		rec_on = rec;
		cfg_index <= CFG_CHANGE_THRESHOLD;
		cfg_data <= thr;
		@(posedge clk);
		thresh = thr;
		cfg_we <= 1'b0;
	endtask

	task automatic send_reading(input reading_t r, input int gap, input bit known,
			input tdl_result_t want);
		tdl_result_t res [2];
		int          n;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.channel_select <= r.ch;
		in_ch.raw_high <= r.hi;
		in_ch.raw_mid <= r.mid;
		in_ch.fault_flag <= r.flt;
		in_ch.time_stamp <= r.ts;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		n = convert_reading(r, res);
		if (known) begin
			pending_results.push_back(want);
		end else begin
			for (int k = 0; k < n; k++)
				pending_results.push_back(res[k]);
		end
	endtask

	initial begin : result_side
		tdl_result_t got;
		tdl_result_t want;
		bit          ready_now;
		int          ready_left;
		ready_now = 1'b0;
		ready_left = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
				got = {out_ch.fault_seen, out_ch.log_valid, out_ch.log_word, out_ch.negative,
					out_ch.whole_degrees, out_ch.tenths_digit, out_ch.last};
				if (pending_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected word, expected none, ", $time,
						"got fault=%0d log=%0d word=%h ",
						got.fault_seen, got.log_valid, got.log_word,
						"neg=%0d whole=%0d tenths=%0d last=%0d",
						got.negative, got.whole_degrees, got.tenths_digit, got.last);
				end else begin
					want = pending_results.pop_front();
					if (got !== want) begin
						errors++;
						$display("%0t: mismatch, ", $time,
							"expected fault=%0d log=%0d word=%h ",
							want.fault_seen, want.log_valid, want.log_word,
							"neg=%0d whole=%0d tenths=%0d last=%0d, ",
							want.negative, want.whole_degrees, want.tenths_digit,
							want.last,
							"got fault=%0d log=%0d word=%h ",
							got.fault_seen, got.log_valid, got.log_word,
							"neg=%0d whole=%0d tenths=%0d last=%0d",
							got.negative, got.whole_degrees, got.tenths_digit, got.last);
					end
				end
			end
			if (ready_left == 0) begin
				ready_now = !ready_now;
				if (ready_now)
					ready_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 20);
				else
					ready_left = $urandom_range(1, 6);
			end
			ready_left--;
			out_ch.ready <= arst_n ? ready_now : 1'b0;
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles <= CycleLimit) begin
			@(posedge clk);
			cycles++;
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin : stimulus
		reading_t         r;
		tdl_result_t      none;
		bit [ValueW-1:0]  v;
		bit               rec_pick;
		bit [ThreshW-1:0] thr_pick;
		int               delta;
		errors = 0;
		burst_left = 0;
		rec_on = 1'b0;
		thresh = ThreshRst;
		logged_val[0] = '0;
		logged_val[1] = '0;
		ch_faulted[0] = 1'b0;
		ch_faulted[1] = 1'b0;
		none = '0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_RECORD_ENABLE;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.channel_select = 1'b0;
		in_ch.raw_high = '0;
		in_ch.raw_mid = '0;
		in_ch.fault_flag = 1'b0;
		in_ch.time_stamp = '0;

		// recording off after reset: display fields only
		add_known(1'b0, 8'h00, 8'h00, 1'b0, 1'b0, 11'd0, 4'd0);
		add_known(1'b0, 8'h3F, 8'hFF, 1'b0, 1'b0, 11'd1023, 4'd9);
		add_known(1'b1, 8'h80, 8'h00, 1'b0, 1'b1, 11'd1024, 4'd0);
		add_known(1'b1, 8'hFF, 8'hFF, 1'b0, 1'b1, 11'd0, 4'd1);
		add_known(1'b0, 8'h40, 8'h01, 1'b0, 1'b0, 11'd0, 4'd0);
		add_known(1'b0, 8'hBF, 8'hEA, 1'b0, 1'b1, 11'd1, 4'd4);
		add_known(1'b1, 8'hBF, 8'hFA, 1'b0, 1'b1, 11'd0, 4'd3);
		add_known(1'b0, 8'h00, 8'h1E, 1'b0, 1'b0, 11'd1, 4'd9);
		add_known(1'b1, 8'h00, 8'h0E, 1'b0, 1'b0, 11'd0, 4'd8);
		add_known(1'b0, 8'h00, 8'h16, 1'b0, 1'b0, 11'd1, 4'd3);
		add_known(1'b0, 8'hFF, 8'hFF, 1'b1, 1'b0, 11'd0, 4'd0);
		add_known(1'b1, 8'h00, 8'h00, 1'b1, 1'b0, 11'd0, 4'd0);
		add_config(1'b1, ThreshRst);
		add_read(1'b0, 8'h00, 8'h06, 1'b0, 8'h11);
		add_read(1'b0, 8'h00, 8'h08, 1'b0, 8'h00);
		add_read(1'b0, 8'h12, 8'h34, 1'b1, 8'h55);
		add_read(1'b0, 8'hBF, 8'hFA, 1'b0, 8'hFF);
		add_read(1'b1, 8'h3F, 8'hFF, 1'b0, 8'h80);
		add_read(1'b1, 8'h3F, 8'hFC, 1'b0, 8'h7F);
		add_config(1'b1, 13'd0);
		add_read(1'b1, 8'h3F, 8'hFA, 1'b0, 8'hA5);
		add_read(1'b1, 8'h3F, 8'hFA, 1'b0, 8'h5A);
		add_config(1'b1, 13'h1FFF);
		add_read(1'b1, 8'h80, 8'h00, 1'b0, 8'h01);
		add_read(1'b1, 8'hFF, 8'hFF, 1'b0, 8'hFE);
		add_read(1'b0, 8'h00, 8'h00, 1'b0, 8'hC3);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == STEP_CONFIG)
				write_config(plan[i].rec, plan[i].thr);
			else
				send_reading(plan[i].rd, next_gap(), plan[i].known, plan[i].want);
		end

		for (int p = 0; p < RandomReadings / PhaseLen; p++) begin
			rec_pick = ($urandom_range(0, 4) != 0);
			case ($urandom_range(0, 3))
				0: thr_pick = '0;
				1: thr_pick = '1;
				2: thr_pick = $urandom_range(0, 16);
				default: thr_pick = $urandom_range(0, 8191);
			endcase
			if (p == 0) begin
				rec_pick = 1'b1;
				thr_pick = '0;
			end else if (p == 1) begin
				rec_pick = 1'b1;
				thr_pick = '1;
			end
			write_config(rec_pick, thr_pick);
			for (int k = 0; k < PhaseLen; k++) begin
				if ($urandom_range(0, 99) == 0)
					drain_results();
				r.ch = $urandom_range(0, 1);
				r.ts = $urandom_range(0, 255);
				r.flt = ($urandom_range(0, 9) == 0);
				if ($urandom_range(0, 99) < 35) begin
					r.hi = $urandom_range(0, 255);
					r.mid = $urandom_range(0, 255);
				end else begin
					// land near the dead-band edge of the channel's logged value
					delta = int'(thresh) + int'($urandom_range(0, 4)) - 2;
					if (delta < 0)
						delta = 0;
					if ($urandom_range(0, 1))
						v = logged_val[r.ch] + ValueW'(delta);
					else
						v = logged_val[r.ch] - ValueW'(delta);
					if ($urandom_range(0, 6) == 0)
						v = 14'h0 - v;
					r.hi = {v[13], 1'($urandom_range(0, 1)), v[12:7]};
					r.mid = {v[6:0], 1'($urandom_range(0, 1))};
				end
				send_reading(r, next_gap(), 1'b0, none);
			end
		end

		drain_results();
		repeat (8) @(posedge clk);
		errors += pending_results.size();
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
